@@ rtl/core/dstdp_pkg.sv @@
// Package for the dopamine-modulated STDP synapse.
// Holds default sizes, time-constant ratios, pair-amplitude constants and the
// elaboration-time functions that build the exponential table.
package dstdp_pkg;

  localparam int EXP_TABLE_DEPTH_DEF = 256;
  localparam int FRAC_BITS_DEF       = 16;

  // 1/T for the potentiation side (T+ = 1/50) and the depression side
  // (T- = 11/100), as numerator over denominator.
  localparam int POS_NUM = 50;
  localparam int POS_DEN = 1;
  localparam int NEG_NUM = 100;
  localparam int NEG_DEN = 11;

  // floor(e * A) is formed as floor(floor(e * A * 5) / 5): A+ = 1/10 is e/2 then /5,
  // A- = 3/20 is 3e/4 then /5. The divide by five uses a reciprocal that is exact
  // for dividends below 2^30.
  localparam int          DIV5_SHIFT = 33;
  localparam logic [33:0] DIV5_RECIP = 34'(((64'd1 << DIV5_SHIFT) + 64'd4) / 64'd5);

  localparam logic [63:0] ONE30 = 64'd1 << 30;

  typedef logic signed [31:0] q16_t;

  // exp(-step) in Q2.30 from a truncated Taylor series.
  function automatic logic [63:0] exp_ratio(input logic [63:0] step);
    logic [63:0]        term;
    logic signed [63:0] q;
    term = ONE30;
    q    = signed'(ONE30);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * step) >> 30) / 64'(n);
      if ((n & 1) == 1) begin
        q = q - signed'(term);
      end else begin
        q = q + signed'(term);
      end
    end
    return unsigned'(q);
  endfunction

  // Table entry idx: repeated truncating multiply by the ratio.
  function automatic logic [30:0] exp_entry(input int idx, input logic [63:0] ratio);
    logic [63:0] e;
    e = ONE30;
    for (int k = 0; k < idx; k++) begin
      e = (e * ratio) >> 30;
    end
    return e[30:0];
  endfunction

  function automatic q16_t sat32(input logic signed [67:0] v);
    q16_t r;
    if (v > 68'sh0_0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -68'sh0_0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/dopamine_stdp_synapse_top.sv @@
// A transmit item goes from IDLE straight to DONE; a plasticity item passes MULK,
// DIV11 (post before pre only), LOOK, PAIR, TRACE, DOP and WEIGHT before DONE, a chain
// of passes through the one shared 34x34 multiplier. s_tready is low while an item is
// in work, so a new item is taken only after the last one has left DONE. Synchronous
// reset clears pending spike, trace and weight to zero and empties the output
// register. Depends on dstdp_pkg.
module dopamine_stdp_synapse_top #(
  parameter int EXP_TABLE_DEPTH = dstdp_pkg::EXP_TABLE_DEPTH_DEF,
  parameter int FRAC_BITS       = dstdp_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pre_spike [0], post_fire_time [32:1], pre_fire_time [64:33], dopamine [96:65],
  // zero fill [103:97]
  input  logic [103:0] s_tdata,
  // opcode [0]
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // contribution [31:0], weight_out [63:32], trace_out [95:64]
  output logic [95:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);
  import dstdp_pkg::*;

  localparam int IdxW  = $clog2(EXP_TABLE_DEPTH);
  localparam int QW    = $clog2(NEG_DEN * EXP_TABLE_DEPTH);
  localparam int S11   = QW + 4;
  localparam int TShft = FRAC_BITS + 3;
  localparam int PairW = FRAC_BITS - 1;
  localparam int PairShift = DIV5_SHIFT + 30 - FRAC_BITS;

  localparam logic [63:0] ExpStep  = (64'd8 << 30) / EXP_TABLE_DEPTH;
  localparam logic [63:0] ExpRatio = exp_ratio(ExpStep);

  // The table index stays below the depth exactly when the time difference is
  // below these limits.
  localparam logic [32:0] LimPos =
    33'(((64'(POS_DEN) << TShft) + 64'(POS_NUM) - 64'd1) / 64'(POS_NUM));
  localparam logic [32:0] LimNeg =
    33'(((64'(NEG_DEN) << TShft) + 64'(NEG_NUM) - 64'd1) / 64'(NEG_NUM));
  localparam logic signed [33:0] KPos  = 34'(POS_NUM * EXP_TABLE_DEPTH);
  localparam logic signed [33:0] KNeg  = 34'(NEG_NUM * EXP_TABLE_DEPTH);
  localparam logic signed [33:0] R11   =
    34'(((64'd1 << S11) + 64'(NEG_DEN) - 64'd1) / 64'(NEG_DEN));

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_MULK   = 9'b000000010,
    ST_DIV11  = 9'b000000100,
    ST_LOOK   = 9'b000001000,
    ST_PAIR   = 9'b000010000,
    ST_TRACE  = 9'b000100000,
    ST_DOP    = 9'b001000000,
    ST_WEIGHT = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_t;

  state_t state;

  logic        pending;
  q16_t        trace;
  q16_t        weight;
  q16_t        contrib;
  logic [31:0] mag;
  logic        neg;
  logic        in_range;
  q16_t        dop;
  logic [29:0] pair_x;
  logic signed [67:0] prod;

  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;

  logic [30:0] exp_rom [EXP_TABLE_DEPTH];

  for (genvar i = 0; i < EXP_TABLE_DEPTH; i++) begin : g_rom
    assign exp_rom[i] = exp_entry(i, ExpRatio);
  end

  logic        in_opcode;
  logic        in_pre_spike;
  logic [31:0] in_post;
  logic [31:0] in_pre;
  logic [32:0] diff_pp;
  logic [32:0] diff_np;
  logic [IdxW-1:0] idx;
  logic [30:0] rom_val;
  logic [32:0] rom_x3;
  logic [PairW-1:0] pair;
  logic signed [34:0] t_sum;
  logic signed [67:0] w_sum;
  logic        out_free;

  assign in_opcode    = s_tuser;
  assign in_pre_spike = s_tdata[0];
  assign in_post      = s_tdata[32:1];
  assign in_pre       = s_tdata[64:33];

  assign s_tready  = (state == ST_IDLE);
  // The weight register is written only between transactions, and an input
  // transaction offered in the same cycle goes first.
  assign cfg_ready = (state == ST_IDLE) && !s_tvalid;
  assign out_free  = !m_tvalid || m_tready;

  // Both differences in parallel; the borrow of post - pre picks the magnitude.
  assign diff_pp = {1'b0, in_post} - {1'b0, in_pre};
  assign diff_np = {1'b0, in_pre} - {1'b0, in_post};

  assign idx     = neg ? prod[S11 +: IdxW] : prod[TShft +: IdxW];
  assign rom_val = exp_rom[idx];
  assign rom_x3  = {2'b00, rom_val} + {1'b0, rom_val, 1'b0};

  assign pair  = prod[PairShift +: PairW];
  assign t_sum = signed'({{(35 - PairW){1'b0}}, pair}) - {trace[31], trace, 2'b00};
  assign w_sum = (prod >>> FRAC_BITS) + 68'(weight);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MULK: begin
        mul_a = {2'b00, mag};
        mul_b = neg ? KNeg : KPos;
      end
      ST_DIV11: begin
        mul_a = 34'(prod[TShft +: QW]);
        mul_b = R11;
      end
      ST_PAIR: begin
        mul_a = {4'b0000, pair_x};
        mul_b = signed'(DIV5_RECIP);
      end
      ST_DOP: begin
        mul_a = 34'(trace);
        mul_b = 34'(dop);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pending  <= 1'b0;
      trace    <= '0;
      weight   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      // Writing initial_weight loads the weight directly.
      if (cfg_valid && cfg_ready) begin
        weight <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (!in_opcode) begin
              contrib <= pending ? weight : '0;
              pending <= in_pre_spike;
              state   <= ST_DONE;
            end else begin
              contrib <= '0;
              neg     <= diff_pp[32];
              mag     <= diff_pp[32] ? diff_np[31:0] : diff_pp[31:0];
              dop     <= s_tdata[96:65];
              state   <= ST_MULK;
            end
          end
        end
        ST_MULK: begin
          in_range <= neg ? ({1'b0, mag} < LimNeg) : ({1'b0, mag} < LimPos);
          state    <= neg ? ST_DIV11 : ST_LOOK;
        end
        ST_DIV11: begin
          state <= ST_LOOK;
        end
        ST_LOOK: begin
          if (!in_range) begin
            pair_x <= '0;
          end else if (neg) begin
            pair_x <= rom_x3[31:2];
          end else begin
            pair_x <= rom_val[30:1];
          end
          state <= ST_PAIR;
        end
        ST_PAIR: begin
          state <= ST_TRACE;
        end
        ST_TRACE: begin
          trace <= sat32(68'(t_sum));
          state <= ST_DOP;
        end
        ST_DOP: begin
          state <= ST_WEIGHT;
        end
        ST_WEIGHT: begin
          weight <= sat32(w_sum);
          state  <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            m_tdata  <= {trace, weight, contrib};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the dopamine-modulated STDP synapse.
// Drives transmit and plasticity transactions, predicts each result in-line and
// checks the output stream field by field. Depends on dstdp_pkg and the synapse top.
`timescale 1ns / 1ps

module tb;

  localparam int EXP_DEPTH  = dstdp_pkg::EXP_TABLE_DEPTH_DEF;
  localparam int FRAC       = dstdp_pkg::FRAC_BITS_DEF;
  localparam int QUIET_LIMIT = 2000;

  typedef enum logic {
    OP_TRANSMIT   = 1'b0,
    OP_PLASTICITY = 1'b1
  } syn_op_t;

  typedef struct packed {
    syn_op_t             op;
    logic                spike;
    logic [31:0]         post_t;
    logic [31:0]         pre_t;
    logic signed [31:0]  dop;
  } syn_item_t;

  typedef struct packed {
    dstdp_pkg::q16_t contribution;
    dstdp_pkg::q16_t weight;
    dstdp_pkg::q16_t trace;
  } syn_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [95:0]  m_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [31:0]  cfg_data = '0;

  dopamine_stdp_synapse_top uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Synapse state as the testbench expects it.
  logic            model_pending = 1'b0;
  dstdp_pkg::q16_t model_trace = '0;
  dstdp_pkg::q16_t model_weight = '0;
  logic [63:0]     exp_q30 [EXP_DEPTH];

  syn_item_t   stim_q [$];
  syn_result_t expected_results [$];
  syn_item_t   cur_item;
  syn_result_t seen_result;
  syn_result_t want_result;
  int          items_queued = 0;
  int          items_accepted = 0;
  int          err_count = 0;
  int          quiet_cycles = 0;
  int unsigned send_idle_pct = 19;
  int unsigned recv_stall_pct = 82;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    $display("tb: %0t %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  // exp(-k * 8 / EXP_DEPTH) in Q2.30, by repeated truncating multiplies with a
  // Taylor-series ratio.
  function automatic void fill_exp_table();
    logic [63:0]        step;
    logic [63:0]        term;
    logic signed [63:0] acc;
    step = (64'd8 << 30) / 64'(EXP_DEPTH);
    term = 64'd1 << 30;
    acc  = 64'sh4000_0000;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * step) >> 30) / 64'(n);
      if (n % 2 == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    exp_q30[0] = 64'd1 << 30;
    for (int i = 1; i < EXP_DEPTH; i++) begin
      exp_q30[i] = (exp_q30[i - 1] * $unsigned(acc)) >> 30;
    end
  endfunction

  function automatic dstdp_pkg::q16_t clamp_q16(input logic signed [63:0] v);
    dstdp_pkg::q16_t r;
    if (v > 64'sh7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] decay_lookup(input logic [63:0] mag, input logic [63:0] num,
                                               input logic [63:0] den);
    logic [63:0] idx;
    idx = (mag * num * 64'(EXP_DEPTH)) / (den * (64'd8 << FRAC));
    return (idx >= 64'(EXP_DEPTH)) ? 64'd0 : exp_q30[idx];
  endfunction

  // Advances the expected synapse state by one item and queues its result.
  function automatic void advance_synapse(input syn_item_t it);
    syn_result_t        r;
    logic signed [63:0] dt;
    logic signed [63:0] pair;
    logic signed [63:0] tr64;
    logic signed [63:0] dop64;
    logic signed [63:0] w64;
    logic [63:0]        e;
    r.contribution = '0;
    if (it.op == OP_TRANSMIT) begin
      if (model_pending) begin
        r.contribution = model_weight;
      end
      model_pending = it.spike;
    end else begin
      dt = $signed({32'd0, it.post_t}) - $signed({32'd0, it.pre_t});
      if (dt >= 0) begin
        e    = decay_lookup(dt, 64'd50, 64'd1);
        pair = $signed((e / 64'd10) >> (30 - FRAC));
      end else begin
        e    = decay_lookup(-dt, 64'd100, 64'd11);
        pair = $signed(((e * 64'd3) / 64'd20) >> (30 - FRAC));
      end
      tr64        = model_trace;
      model_trace = clamp_q16(pair - 64'sd4 * tr64);
      tr64        = model_trace;
      dop64       = it.dop;
      w64         = model_weight;
      // Arithmetic shift of the product rounds toward minus infinity.
      model_weight = clamp_q16(w64 + ((dop64 * tr64) >>> FRAC));
    end
    r.weight = model_weight;
    r.trace  = model_trace;
    expected_results = {expected_results, r};
  endfunction

  function automatic syn_item_t make_item(input syn_op_t op, input logic spike,
                                          input logic [31:0] post_t, input logic [31:0] pre_t,
                                          input logic [31:0] dop);
    syn_item_t it;
    it.op     = op;
    it.spike  = spike;
    it.post_t = post_t;
    it.pre_t  = pre_t;
    it.dop    = dop;
    return it;
  endfunction

  function automatic syn_item_t random_item();
    syn_item_t   it;
    int unsigned pick;
    int          dt;
    it.op     = ($urandom_range(99) < 40) ? OP_TRANSMIT : OP_PLASTICITY;
    it.spike  = 1'($urandom_range(1));
    it.post_t = $urandom;
    it.pre_t  = $urandom;
    it.dop    = $urandom;
    if (it.op == OP_PLASTICITY) begin
      // Mostly time differences that land inside the table, on both sides.
      pick = $urandom_range(99);
      if (pick < 70) begin
        dt        = int'($urandom_range(72000)) - 60000;
        it.pre_t  = $urandom_range(32'hFFF0_0000, 32'h0010_0000);
        it.post_t = it.pre_t + dt;
      end else if (pick < 85) begin
        dt        = int'($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
        it.pre_t  = $urandom_range(32'hFFD0_0000, 32'h0030_0000);
        it.post_t = it.pre_t + dt;
      end
      pick = $urandom_range(99);
      if (pick < 50) begin
        it.dop = int'($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
      end else if (pick < 80) begin
        it.dop = int'($urandom_range(512)) - 256;
      end
    end
    return it;
  endfunction

  task automatic queue_item(input syn_item_t it);
    stim_q = {stim_q, it};
    items_queued++;
  endtask

  task automatic wait_drained();
    while (items_accepted != items_queued || expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_initial_weight(input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    model_weight  = value;
  endtask

  // Stimulus driver: one transaction per handshake, random gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        advance_synapse(cur_item);
        items_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = stim_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {7'd0, cur_item.dop, cur_item.pre_t, cur_item.post_t, cur_item.spike};
          s_tuser  <= cur_item.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Output monitor and watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        seen_result = '{m_tdata[31:0], m_tdata[63:32], m_tdata[95:64]};
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", seen_result.weight, '0);
        end else begin
          want_result = expected_results.pop_front();
          if (seen_result.contribution !== want_result.contribution) begin
            report_mismatch("contribution", seen_result.contribution,
                            want_result.contribution);
          end
          if (seen_result.weight !== want_result.weight) begin
            report_mismatch("weight_out", seen_result.weight, want_result.weight);
          end
          if (seen_result.trace !== want_result.trace) begin
            report_mismatch("trace_out", seen_result.trace, want_result.trace);
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    fill_exp_table();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    write_initial_weight(32'h7FFF_FFFF);
    // Spike latching: the weight only goes out on the transmit after a spike.
    queue_item(make_item(OP_TRANSMIT, 1'b1, 32'd0, 32'd0, 32'd0));
    queue_item(make_item(OP_TRANSMIT, 1'b0, 32'd0, 32'd0, 32'd0));
    queue_item(make_item(OP_TRANSMIT, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    queue_item(make_item(OP_TRANSMIT, 1'b1, 32'd0, 32'd0, 32'd0));
    // A plasticity item must not disturb the latched spike.
    queue_item(make_item(OP_PLASTICITY, 1'b0, 32'd5000, 32'd5000, 32'd0));
    queue_item(make_item(OP_TRANSMIT, 1'b0, 32'd0, 32'd0, 32'd0));
    queue_item(make_item(OP_PLASTICITY, 1'b1, 32'd12047, 32'd10000, 32'd1));
    queue_item(make_item(OP_PLASTICITY, 1'b0, 32'd12048, 32'd10000, 32'hFFFF_FFFF));
    // Last table entry and the first index past the end of the table.
    queue_item(make_item(OP_PLASTICITY, 1'b1, 32'd10485, 32'd0, 32'h0000_0100));
    queue_item(make_item(OP_PLASTICITY, 1'b0, 32'd10486, 32'd0, 32'hFFFF_FF00));
    queue_item(make_item(OP_PLASTICITY, 1'b0, 32'd99, 32'd100, 32'h7FFF_FFFF));
    queue_item(make_item(OP_PLASTICITY, 1'b0, 32'd0, 32'd57671, 32'h8000_0000));
    queue_item(make_item(OP_PLASTICITY, 1'b1, 32'd0, 32'd57672, 32'h0001_0000));
    queue_item(make_item(OP_PLASTICITY, 1'b0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_0000));
    queue_item(make_item(OP_PLASTICITY, 1'b0, 32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
    queue_item(make_item(OP_TRANSMIT, 1'b1, 32'd0, 32'd0, 32'd0));
    queue_item(make_item(OP_TRANSMIT, 1'b0, 32'd0, 32'd0, 32'd0));
    queue_item(make_item(OP_PLASTICITY, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    queue_item(make_item(OP_PLASTICITY, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001));
    wait_drained();

    write_initial_weight(32'h8000_0000);
    queue_item(make_item(OP_TRANSMIT, 1'b1, 32'd0, 32'd0, 32'd0));
    queue_item(make_item(OP_TRANSMIT, 1'b0, 32'd0, 32'd0, 32'd0));
    for (int i = 0; i < 300; i++) begin
      queue_item(random_item());
    end
    wait_drained();

    write_initial_weight($urandom);
    send_idle_pct  = 82;
    recv_stall_pct = 19;
    for (int i = 0; i < 300; i++) begin
      queue_item(random_item());
    end
    wait_drained();

    write_initial_weight(32'h0000_0000);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 300; i++) begin
      queue_item(random_item());
    end
    wait_drained();

    repeat (20) @(posedge clk);
    while (expected_results.size() != 0) begin
      want_result = expected_results.pop_front();
      report_mismatch("missing result, weight", '0, want_result.weight);
    end
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
